/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the ordered dwell round robin RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is high
`define ODRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ODRR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/odrr_pkg.sv */
// ----------------------------------------------------------------------------
// odrr_pkg
// Shared types and codes of the ordered dwell round robin block
// ----------------------------------------------------------------------------
package odrr_pkg;

  localparam int KEY_W = 8;

  // operation codes
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  // per-cell control from the table controller
  typedef struct packed {
    logic insert;    // a member is being inserted this cycle
    logic occupied;  // cell holds a member
  } cell_ctl_t;

endpackage

/* src/ordered_dwell_round_robin_top.sv */
// ----------------------------------------------------------------------------
// ordered_dwell_round_robin_top
// Sorted member table with time-sliced round robin over its members
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries either a register transaction,
// which inserts a member in key order behind any equal keys, or a tick
// transaction with a presence flag that advances the dwell counter.
// Output channel (out_valid/out_stall) returns one result per input
// transaction: group activity, shown member id, member count and status.
// A register into a full table is dropped and reports the full status.
// The result appears in the output register on the cycle after the input
// transaction is taken. Throughput is one transaction per cycle unless
// stalled; the table is a row of compare-and-shift cells that all update
// in the same cycle, and a tick reads the current slot through one mux.
// When the receiver stalls, the result holds and in_stall rises until the
// result is taken, so a new transaction waits at most one stalled result.
// Synchronous reset empties the table, clears the counter, current slot,
// activity flag and output valid; table contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_dwell_round_robin_top #(
  parameter int MAX_MEMBERS = 8,
  parameter int DWELL_BITS  = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  odrr_pkg::key_t                    order_key,
  input  logic [DWELL_BITS-1:0]             dwell_ticks,
  input  logic [ID_BITS-1:0]                member_id,
  input  logic                              presence,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              group_active,
  output logic [ID_BITS-1:0]                shown_member,
  output logic [$clog2(MAX_MEMBERS+1)-1:0]  member_total,
  output logic                              status
);

  localparam int SLOT_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);

  logic [CNT_W-1:0]      member_count;
  logic [CNT_W-1:0]      member_count_next;
  logic [SLOT_W-1:0]     current_slot;
  logic [SLOT_W-1:0]     current_slot_next;
  logic [DWELL_BITS-1:0] step_counter;
  logic [DWELL_BITS-1:0] step_counter_next;
  logic                  active_flag;
  logic                  active_flag_next;

  logic                  in_fire;
  logic                  full;
  logic                  do_insert;
  logic                  do_tick;
  logic [ID_BITS-1:0]    shown_next;
  logic                  status_next;

  logic [SLOT_W-1:0]     tick_slot;
  logic [DWELL_BITS-1:0] step_inc;
  logic [CNT_W-1:0]      slot_up;

  odrr_pkg::cell_ctl_t   cell_ctl [MAX_MEMBERS];
  logic                  cell_after [MAX_MEMBERS];
  odrr_pkg::key_t        cell_key [MAX_MEMBERS];
  logic [DWELL_BITS-1:0] cell_dwell [MAX_MEMBERS];
  logic [ID_BITS-1:0]    cell_id [MAX_MEMBERS];
  logic [ID_BITS-1:0]    cell_id_next [MAX_MEMBERS];

  assign in_stall  = out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign full      = (member_count == CNT_W'(MAX_MEMBERS));
  assign do_insert = in_fire && (operation == odrr_pkg::OP_REGISTER) && !full;
  assign do_tick   = in_fire && (operation == odrr_pkg::OP_TICK);

  // row of slot cells, each hands its member to the right on insertion
  for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
    assign cell_ctl[i].insert   = do_insert;
    assign cell_ctl[i].occupied = CNT_W'(i) < member_count;

    if (i == 0) begin : g_head
      odrr_cell #(
        .DWELL_BITS (DWELL_BITS),
        .ID_BITS    (ID_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .new_key    (order_key),
        .new_dwell  (dwell_ticks),
        .new_id     (member_id),
        .prev_after (1'b0),
        .prev_key   ('0),
        .prev_dwell ('0),
        .prev_id    ('0),
        .after      (cell_after[i]),
        .key        (cell_key[i]),
        .dwell      (cell_dwell[i]),
        .id         (cell_id[i]),
        .id_next    (cell_id_next[i])
      );
    end else begin : g_body
      odrr_cell #(
        .DWELL_BITS (DWELL_BITS),
        .ID_BITS    (ID_BITS)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[i]),
        .new_key    (order_key),
        .new_dwell  (dwell_ticks),
        .new_id     (member_id),
        .prev_after (cell_after[i-1]),
        .prev_key   (cell_key[i-1]),
        .prev_dwell (cell_dwell[i-1]),
        .prev_id    (cell_id[i-1]),
        .after      (cell_after[i]),
        .key        (cell_key[i]),
        .dwell      (cell_dwell[i]),
        .id         (cell_id[i]),
        .id_next    (cell_id_next[i])
      );
    end
  end

  // tick path
  assign tick_slot = (CNT_W'(current_slot) < member_count) ? current_slot : '0;
  assign step_inc  = (step_counter == '1) ? step_counter : step_counter + 1'b1;
  assign slot_up   = CNT_W'(tick_slot) + CNT_W'(1);

  always_comb begin
    member_count_next = member_count;
    current_slot_next = current_slot;
    step_counter_next = step_counter;
    active_flag_next  = active_flag;
    status_next       = odrr_pkg::ST_OK;
    shown_next        = '0;

    if (in_fire && (operation == odrr_pkg::OP_REGISTER)) begin
      if (full) begin
        status_next = odrr_pkg::ST_FULL;
      end else begin
        member_count_next = member_count + CNT_W'(1);
      end
    end

    if (do_tick) begin
      active_flag_next = presence && (member_count != '0);
      if (active_flag_next) begin
        current_slot_next = tick_slot;
        step_counter_next = step_inc;
        if (cell_dwell[tick_slot] <= step_inc) begin
          step_counter_next = '0;
          current_slot_next = (slot_up < member_count) ? SLOT_W'(slot_up) : '0;
        end
      end
    end

    if (active_flag_next && (CNT_W'(current_slot_next) < member_count_next)) begin
      shown_next = cell_id_next[current_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member_count <= '0;
      current_slot <= '0;
      step_counter <= '0;
      active_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      member_count <= member_count_next;
      current_slot <= current_slot_next;
      step_counter <= step_counter_next;
      active_flag  <= active_flag_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      group_active <= active_flag_next;
      shown_member <= shown_next;
      member_total <= member_count_next;
      status       <= status_next;
    end
  end

  `ODRR_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && member_count == '0,
    "reset left a result or members behind")
  `ODRR_ASSERT(a_count_range, member_count <= CNT_W'(MAX_MEMBERS),
    "member count above table size")
  `ODRR_ASSERT(a_full_drop,
    in_fire && (operation == odrr_pkg::OP_REGISTER) && full |=>
      member_count == CNT_W'(MAX_MEMBERS) && status == odrr_pkg::ST_FULL,
    "register into full table changed the count")
  `ODRR_ASSERT(a_insert_count,
    do_insert |=> member_count == $past(member_count) + CNT_W'(1),
    "insert did not grow the table by one")
  `ODRR_ASSERT(a_active_nonempty, out_valid && group_active |-> member_total != '0,
    "active group reported with no members")

endmodule

/* src/odrr_cell.sv */
// ----------------------------------------------------------------------------
// odrr_cell
// One table slot: compares the incoming key and either keeps its member,
// takes the new member, or takes its left neighbor's member
// ----------------------------------------------------------------------------
module odrr_cell #(
  parameter int DWELL_BITS = 16,
  parameter int ID_BITS    = 8
) (
  input  logic                  clk,
  input  odrr_pkg::cell_ctl_t   ctl,
  input  odrr_pkg::key_t        new_key,
  input  logic [DWELL_BITS-1:0] new_dwell,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic                  prev_after,
  input  odrr_pkg::key_t        prev_key,
  input  logic [DWELL_BITS-1:0] prev_dwell,
  input  logic [ID_BITS-1:0]    prev_id,
  output logic                  after,
  output odrr_pkg::key_t        key,
  output logic [DWELL_BITS-1:0] dwell,
  output logic [ID_BITS-1:0]    id,
  output logic [ID_BITS-1:0]    id_next
);

  odrr_pkg::key_t        key_next;
  logic [DWELL_BITS-1:0] dwell_next;

  // slot sits at or beyond the insertion point
  assign after = !ctl.occupied || (new_key < key);

  always_comb begin
    key_next   = key;
    dwell_next = dwell;
    id_next    = id;
    if (ctl.insert) begin
      if (prev_after) begin
        key_next   = prev_key;
        dwell_next = prev_dwell;
        id_next    = prev_id;
      end else if (after) begin
        key_next   = new_key;
        dwell_next = new_dwell;
        id_next    = new_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    dwell <= dwell_next;
    id    <= id_next;
  end

endmodule

/* tb/odrr_score_pkg.sv */
// ----------------------------------------------------------------------------
// odrr_score_pkg
// Result predictor and scoreboard for the ordered dwell round robin block
// ----------------------------------------------------------------------------
// Keeps its own copy of the sorted member table, the step counter and the
// current slot. Works out one expected result per accepted transaction and
// compares results from the block against them in order.
// ----------------------------------------------------------------------------
package odrr_score_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int DWELL_W     = 16;
  localparam int ID_W        = 8;
  localparam int TOTAL_W     = 4;

  typedef struct packed {
    logic              active;
    logic [ID_W-1:0]   shown;
    logic [TOTAL_W-1:0] total;
    logic              status;
  } rr_result_t;

  class dwell_scoreboard;
    odrr_pkg::key_t     keys   [TABLE_DEPTH];
    logic [DWELL_W-1:0] dwells [TABLE_DEPTH];
    logic [ID_W-1:0]    ids    [TABLE_DEPTH];
    int unsigned        count;
    int unsigned        slot;
    logic [DWELL_W-1:0] step;
    logic               active;
    rr_result_t         expected_q[$];
    int unsigned        errors;
    int unsigned        n_checked;
    int unsigned        n_ticks;
    int unsigned        n_regs;
    int unsigned        n_dropped;
    int unsigned        n_rotations;

    function new();
      foreach (keys[i]) begin
        keys[i]   = '0;
        dwells[i] = '0;
        ids[i]    = '0;
      end
      count       = 0;
      slot        = 0;
      step        = '0;
      active      = 1'b0;
      errors      = 0;
      n_checked   = 0;
      n_ticks     = 0;
      n_regs      = 0;
      n_dropped   = 0;
      n_rotations = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // predict the result of one accepted transaction
    function void note_item(logic op, odrr_pkg::key_t key, logic [DWELL_W-1:0] dwell,
                            logic [ID_W-1:0] id, logic pres);
      rr_result_t r;
      int unsigned pos;
      bit found;
      r.status = odrr_pkg::ST_OK;
      if (op == odrr_pkg::OP_REGISTER) begin
        n_regs++;
        if (count >= TABLE_DEPTH) begin
          r.status = odrr_pkg::ST_FULL;
          n_dropped++;
        end else begin
          // first slot with a strictly greater key, so equal keys stay in order
          pos = count;
          found = 1'b0;
          for (int i = 0; i < count; i++) begin
            if (!found && key < keys[i]) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (int i = count; i > pos; i--) begin
            keys[i]   = keys[i-1];
            dwells[i] = dwells[i-1];
            ids[i]    = ids[i-1];
          end
          keys[pos]   = key;
          dwells[pos] = dwell;
          ids[pos]    = id;
          count++;
        end
      end else begin
        n_ticks++;
        active = pres && (count != 0);
        if (active) begin
          if (slot >= count) slot = 0;
          if (step != {DWELL_W{1'b1}}) step++;
          if (dwells[slot] <= step) begin
            step = '0;
            slot = (slot + 1 < count) ? slot + 1 : 0;
            n_rotations++;
          end
        end
      end
      r.active = active;
      r.shown  = (active && slot < count) ? ids[slot] : '0;
      r.total  = count[TOTAL_W-1:0];
      expected_q.push_back(r);
    endfunction

    // compare one result from the block with the oldest expectation
    function void check_result(rr_result_t got);
      rr_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result active=%0b shown=%0h total=%0d status=%0b",
                 $time, got.active, got.shown, got.total, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (got !== exp_r) begin
        errors++;
        $display("%0t: result %0d expected %0b/%0h/%0d/%0b got %0b/%0h/%0d/%0b",
                 $time, n_checked, exp_r.active, exp_r.shown, exp_r.total,
                 exp_r.status, got.active, got.shown, got.total, got.status);
      end
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for ordered_dwell_round_robin_top
// ----------------------------------------------------------------------------
// A directed opening walks through an empty group, equal and lower keys,
// insertion into an active group, a counter left above the new dwell, zero
// dwell and wrap-around. Random register and tick transactions follow with
// random idling on both channels, one long output hold-off and one pause of
// the sender until the block has drained. Every result is checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1030;
  localparam int IDLE_PCT     = 29;
  localparam int HOLD_CYCLES  = 80;
  localparam int TABLE_DEPTH  = odrr_score_pkg::TABLE_DEPTH;
  localparam int DWELL_W      = odrr_score_pkg::DWELL_W;
  localparam int ID_W         = odrr_score_pkg::ID_W;
  localparam int TOTAL_W      = odrr_score_pkg::TOTAL_W;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               operation;
  odrr_pkg::key_t     order_key;
  logic [DWELL_W-1:0] dwell_ticks;
  logic [ID_W-1:0]    member_id;
  logic               presence;
  logic               out_valid;
  logic               out_stall;
  logic               group_active;
  logic [ID_W-1:0]    shown_member;
  logic [TOTAL_W-1:0] member_total;
  logic               status;

  odrr_score_pkg::dwell_scoreboard sb;
  bit          sender_idle_en;
  int unsigned regs_sent;

  ordered_dwell_round_robin_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .order_key    (order_key),
    .dwell_ticks  (dwell_ticks),
    .member_id    (member_id),
    .presence     (presence),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .group_active (group_active),
    .shown_member (shown_member),
    .member_total (member_total),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("ordered_dwell_round_robin_top: mismatch");
    $finish;
  end

  // offer one transaction and hold it until it is taken; called at a falling edge
  task automatic send(logic op, odrr_pkg::key_t key, logic [DWELL_W-1:0] dwell,
                      logic [ID_W-1:0] id, logic pres);
    while (sender_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    order_key   <= key;
    dwell_ticks <= dwell;
    member_id   <= id;
    presence    <= pres;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, key, dwell, id, pres);
    if (op == odrr_pkg::OP_REGISTER) regs_sent++;
    @(negedge clk);
  endtask

  task automatic tick(logic pres);
    send(odrr_pkg::OP_TICK, odrr_pkg::key_t'($urandom), DWELL_W'($urandom),
         ID_W'($urandom), pres);
  endtask

  task automatic run_directed();
    tick(1'b1);                              // empty table stays inactive
    tick(1'b0);
    send(odrr_pkg::OP_REGISTER, 8'd128, 16'd2, 8'hFF, 1'b1);
    tick(1'b1);
    send(odrr_pkg::OP_REGISTER, 8'd128, 16'd0, 8'h01, 1'b0);  // equal key goes behind
    send(odrr_pkg::OP_REGISTER, 8'd0, 16'd3, 8'h00, 1'b1);    // lands under the current slot
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    tick(1'b1);
    // counter already past the dwell of the member now at the current slot
    send(odrr_pkg::OP_REGISTER, 8'd100, 16'd0, 8'h5A, 1'b0);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    tick(1'b1);                              // zero dwell, then wrap to the first
    send(odrr_pkg::OP_REGISTER, 8'd255, 16'd4, 8'h80, 1'b1);
    repeat (6) tick(1'b1);
  endtask

  task automatic run_random();
    logic op;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_idle_en = !(i >= 600 && i < 800);
      if (i == 520) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      op = ($urandom_range(0, 99) < ((regs_sent < TABLE_DEPTH) ? 6 : 12))
           ? odrr_pkg::OP_REGISTER : odrr_pkg::OP_TICK;
      if (op == odrr_pkg::OP_REGISTER && regs_sent < TABLE_DEPTH)
        // members that stay in the table keep short dwells so the group rotates
        send(op, odrr_pkg::key_t'($urandom_range(0, 255)),
             DWELL_W'($urandom_range(0, 6)), ID_W'($urandom_range(0, 255)), 1'($urandom));
      else if (op == odrr_pkg::OP_REGISTER)
        send(op, odrr_pkg::key_t'($urandom), DWELL_W'($urandom), ID_W'($urandom),
             1'($urandom));
      else
        tick($urandom_range(0, 99) < 85);
    end
    in_valid <= 1'b0;
  endtask

  // output stall: random, one long hold-off, and a quiet stretch
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.n_checked >= 300) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (sb.n_checked >= 750 && sb.n_checked < 950) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{active: group_active, shown: shown_member,
                        total: member_total, status: status});
  end

  initial begin
    sb = new();
    sender_idle_en = 1'b1;
    regs_sent   = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = odrr_pkg::OP_TICK;
    order_key   = '0;
    dwell_ticks = '0;
    member_id   = '0;
    presence    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    run_directed();
    run_random();
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("covered %0d register transactions (%0d dropped on a full table), %0d ticks",
             sb.n_regs, sb.n_dropped, sb.n_ticks);
    $display("%0d results checked, %0d rotations to the next member",
             sb.n_checked, sb.n_rotations);
    if (sb.errors == 0)
      $display("ordered_dwell_round_robin_top: match");
    else
      $display("ordered_dwell_round_robin_top: mismatch");
    $finish;
  end

endmodule
